@@ src/mdr_pkg.sv @@
// shared types, constants and the arctangent table of the mecanum dead reckoning block
package mdr_pkg;

  // cordic datapath widths
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 32;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 39;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // cordic gain, Q1.30
  localparam logic [ZW-1:0] GAIN_Q30 = 32'd652032874;

  // quadrant constants on a 32-bit binary angle
  localparam logic [ZW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ZW-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // configuration register indexes
  localparam logic CFG_SPEED_SCALE = 1'b0;
  localparam logic CFG_WHEEL_INVERT = 1'b1;

  // input modes
  localparam logic [1:0] MODE_WHEEL = 2'd0;
  localparam logic [1:0] MODE_ORIENT = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // request to the cordic unit
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_req_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/mecanum_dead_reckoning.sv @@
// Mecanum dead reckoning: a wheel transaction (mode 0) forms four products on the shared
// multiplier; an orientation transaction (mode 1) forms four products and then makes one
// vectoring pass through the cordic unit, skipped when both operands are zero; a tick (mode 2)
// makes two passes through the single cordic unit and forms four products on the single
// multiplier. Input stall stays high for the whole transaction. The pose result is held in an
// output register; a tick waits at its end only while an earlier result is still stalled.
module mecanum_dead_reckoning
  import mdr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [14:0] wheel_speed_0_i,
  input  logic signed [14:0] wheel_speed_1_i,
  input  logic signed [14:0] wheel_speed_2_i,
  input  logic signed [14:0] wheel_speed_3_i,
  input  logic [19:0]        elapsed_us_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] orient_w_o,
  output logic signed [15:0] orient_z_o,
  output logic signed [15:0] yaw_out_o
);

  localparam int unsigned AB = ANGLE_BITS;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M0_1 = 5'd1;
  localparam logic [4:0] S_M0_2 = 5'd2;
  localparam logic [4:0] S_M0_3 = 5'd3;
  localparam logic [4:0] S_M0_4 = 5'd4;
  localparam logic [4:0] S_M0_5 = 5'd5;
  localparam logic [4:0] S_M1_1 = 5'd6;
  localparam logic [4:0] S_M1_2 = 5'd7;
  localparam logic [4:0] S_M1_3 = 5'd8;
  localparam logic [4:0] S_M1_4 = 5'd9;
  localparam logic [4:0] S_M1_5 = 5'd10;
  localparam logic [4:0] S_M1_6 = 5'd11;
  localparam logic [4:0] S_M1_W = 5'd12;
  localparam logic [4:0] S_M1_F = 5'd13;
  localparam logic [4:0] S_M2_0 = 5'd14;
  localparam logic [4:0] S_M2_W1 = 5'd15;
  localparam logic [4:0] S_M2_1 = 5'd16;
  localparam logic [4:0] S_M2_2 = 5'd17;
  localparam logic [4:0] S_M2_3 = 5'd18;
  localparam logic [4:0] S_M2_4 = 5'd19;
  localparam logic [4:0] S_M2_5 = 5'd20;
  localparam logic [4:0] S_M2_W2 = 5'd21;
  localparam logic [4:0] S_M2_O = 5'd22;

  localparam logic signed [MUL_P_W-1:0] STEP_MAX = MUL_P_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [MUL_P_W-1:0] STEP_MIN = -STEP_MAX - MUL_P_W'(1);
  localparam logic signed [MUL_P_W:0] ROUND_46 = (MUL_P_W + 1)'(1) <<< 45;
  localparam logic signed [35:0] ONE_Q30 = 36'sd1 <<< 30;

  logic [4:0] state_q, state_d;
  logic [15:0] scale_q, scale_d;
  logic [3:0] inv_q, inv_d;
  logic signed [17:0] sum_q, sum_d, dif_q, dif_d;
  logic [19:0] el_q, el_d;
  logic signed [15:0] qw_q, qw_d, qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic signed [MUL_P_W:0] acc_q, acc_d;
  logic signed [35:0] num_q, num_d, den_q, den_d;
  logic [ZW-1:0] raw32_q, raw32_d;
  logic neg_q, neg_d;
  logic signed [31:0] c_q, c_d, s_q, s_d;
  logic signed [47:0] fwd_q, fwd_d, lat_q, lat_d;
  logic [AB-1:0] head_q, head_d, ref_q, ref_d;
  logic captured_q, captured_d;
  logic signed [31:0] accx_q, accx_d, accy_q, accy_d;
  logic out_valid_q, out_valid_d;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic signed [15:0] ow_q, ow_d, oz_q, oz_d, yaw_q, yaw_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  cordic_req_t cd_req;
  logic signed [CW-1:0] cd_x0, cd_y0, cd_x, cd_y;
  logic [ZW-1:0] cd_z0, cd_z;
  logic cd_done;

  logic signed [15:0] spd [4];
  logic [ZW-1:0] h32, half32, raw_sum;
  logic signed [MUL_P_W:0] mix;
  logic signed [33:0] delta, pos_sum;

  mdr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mdr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cd_req),
    .x0_i   (cd_x0),
    .y0_i   (cd_y0),
    .z0_i   (cd_z0),
    .done_o (cd_done),
    .x_o    (cd_x),
    .y_o    (cd_y),
    .z_o    (cd_z)
  );

  // saturate a product to a 48-bit step
  function automatic logic signed [47:0] sat48(input logic signed [MUL_P_W-1:0] v);
    logic signed [47:0] r;
    if (v > STEP_MAX) r = STEP_MAX[47:0];
    else if (v < STEP_MIN) r = STEP_MIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  // saturate a position sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Q1.30 to Q1.15, rounded half up and saturated
  function automatic logic signed [15:0] q30_to_q15(input logic signed [31:0] v);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = (34'(v) + 34'sd16384) >>> 15;
    if (t > 34'sd32767) r = 16'sh7FFF;
    else if (t < -34'sd32768) r = 16'sh8000;
    else r = t[15:0];
    return r;
  endfunction

  // fold the angle into the right half plane, cos and sin negated later
  function automatic logic [ZW:0] fold_angle(input logic [ZW-1:0] a);
    logic n;
    n = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    return {n, n ? a + HALF_TURN : a};
  endfunction

  assign h32 = ZW'(head_q) << (ZW - AB);
  assign half32 = {h32[ZW-1], h32[ZW-1:1]};

  // sequencer and datapath
  always_comb begin
    state_d = state_q;
    scale_d = scale_q;
    inv_d = inv_q;
    sum_d = sum_q;
    dif_d = dif_q;
    el_d = el_q;
    qw_d = qw_q;
    qx_d = qx_q;
    qy_d = qy_q;
    qz_d = qz_q;
    acc_d = acc_q;
    num_d = num_q;
    den_d = den_q;
    raw32_d = raw32_q;
    neg_d = neg_q;
    c_d = c_q;
    s_d = s_q;
    fwd_d = fwd_q;
    lat_d = lat_q;
    head_d = head_q;
    ref_d = ref_q;
    captured_d = captured_q;
    accx_d = accx_q;
    accy_d = accy_q;
    out_valid_d = out_valid_q && out_stall_i;
    px_d = px_q;
    py_d = py_q;
    ow_d = ow_q;
    oz_d = oz_q;
    yaw_d = yaw_q;
    mul_a = '0;
    mul_b = '0;
    cd_req = '{start: 1'b0, vectoring: 1'b0};
    cd_x0 = '0;
    cd_y0 = '0;
    cd_z0 = '0;
    raw_sum = raw32_q + (ZW'(1) << (31 - AB));
    mix = acc_q - (MUL_P_W + 1)'(mul_p) + ROUND_46;
    delta = 34'(mix >>> 46);
    pos_sum = '0;

    spd[0] = inv_q[0] ? -16'(wheel_speed_0_i) : 16'(wheel_speed_0_i);
    spd[1] = inv_q[1] ? -16'(wheel_speed_1_i) : 16'(wheel_speed_1_i);
    spd[2] = inv_q[2] ? -16'(wheel_speed_2_i) : 16'(wheel_speed_2_i);
    spd[3] = inv_q[3] ? -16'(wheel_speed_3_i) : 16'(wheel_speed_3_i);

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED_SCALE: scale_d = cfg_data_i;
        CFG_WHEEL_INVERT: inv_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sum_d = 18'(spd[0]) + 18'(spd[1]) + 18'(spd[2]) + 18'(spd[3]);
          dif_d = -18'(spd[0]) + 18'(spd[1]) - 18'(spd[2]) + 18'(spd[3]);
          el_d = elapsed_us_i;
          qw_d = quat_w_i;
          qx_d = quat_x_i;
          qy_d = quat_y_i;
          qz_d = quat_z_i;
          case (mode_i)
            MODE_WHEEL: state_d = S_M0_1;
            MODE_ORIENT: state_d = S_M1_1;
            MODE_TICK: state_d = S_M2_0;
            default: state_d = S_IDLE;
          endcase
        end
      end
      // wheel sample: speed sum and difference times elapsed times scale
      S_M0_1: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = MUL_B_W'({1'b0, el_q});
        state_d = S_M0_2;
      end
      S_M0_2: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'({1'b0, scale_q});
        state_d = S_M0_3;
      end
      S_M0_3: begin
        fwd_d = sat48(mul_p);
        mul_a = MUL_A_W'(dif_q);
        mul_b = MUL_B_W'({1'b0, el_q});
        state_d = S_M0_4;
      end
      S_M0_4: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'({1'b0, scale_q});
        state_d = S_M0_5;
      end
      S_M0_5: begin
        lat_d = sat48(mul_p);
        state_d = S_IDLE;
      end
      // orientation sample: atan2 operands from the quaternion
      S_M1_1: begin
        mul_a = MUL_A_W'(qw_q);
        mul_b = MUL_B_W'(qz_q);
        state_d = S_M1_2;
      end
      S_M1_2: begin
        acc_d = (MUL_P_W + 1)'(mul_p);
        mul_a = MUL_A_W'(qx_q);
        mul_b = MUL_B_W'(qy_q);
        state_d = S_M1_3;
      end
      S_M1_3: begin
        num_d = (36'(acc_q) + 36'(mul_p)) <<< 1;
        mul_a = MUL_A_W'(qy_q);
        mul_b = MUL_B_W'(qy_q);
        state_d = S_M1_4;
      end
      S_M1_4: begin
        acc_d = (MUL_P_W + 1)'(mul_p);
        mul_a = MUL_A_W'(qz_q);
        mul_b = MUL_B_W'(qz_q);
        state_d = S_M1_5;
      end
      S_M1_5: begin
        den_d = ONE_Q30 - ((36'(acc_q) + 36'(mul_p)) <<< 1);
        state_d = S_M1_6;
      end
      S_M1_6: begin
        if (num_q == '0 && den_q == '0) begin
          raw32_d = '0;
          state_d = S_M1_F;
        end else begin
          cd_req = '{start: 1'b1, vectoring: 1'b1};
          if (den_q < 0) begin
            if (num_q >= 0) begin
              cd_x0 = CW'(num_q);
              cd_y0 = -CW'(den_q);
              cd_z0 = QUARTER_TURN;
            end else begin
              cd_x0 = -CW'(num_q);
              cd_y0 = CW'(den_q);
              cd_z0 = THREE_QUARTER_TURN;
            end
          end else begin
            cd_x0 = CW'(den_q);
            cd_y0 = CW'(num_q);
          end
          state_d = S_M1_W;
        end
      end
      S_M1_W: begin
        if (cd_done) begin
          raw32_d = cd_z;
          state_d = S_M1_F;
        end
      end
      // yaw relative to the first sample
      S_M1_F: begin
        if (!captured_q) begin
          ref_d = raw_sum[ZW-1 -: AB];
          captured_d = 1'b1;
          head_d = '0;
        end else begin
          head_d = raw_sum[ZW-1 -: AB] - ref_q;
        end
        state_d = S_IDLE;
      end
      // tick: cos and sin of the heading
      S_M2_0: begin
        cd_req = '{start: 1'b1, vectoring: 1'b0};
        {neg_d, cd_z0} = fold_angle(h32);
        cd_x0 = CW'(GAIN_Q30);
        state_d = S_M2_W1;
      end
      S_M2_W1: begin
        if (cd_done) begin
          c_d = neg_q ? -cd_x[31:0] : cd_x[31:0];
          s_d = neg_q ? -cd_y[31:0] : cd_y[31:0];
          state_d = S_M2_1;
        end
      end
      // rotate the pending step into the world frame
      S_M2_1: begin
        mul_a = MUL_A_W'($signed(fwd_q[47:16]));
        mul_b = c_q;
        state_d = S_M2_2;
      end
      S_M2_2: begin
        acc_d = (MUL_P_W + 1)'(mul_p);
        mul_a = MUL_A_W'($signed(lat_q[47:16]));
        mul_b = s_q;
        state_d = S_M2_3;
      end
      S_M2_3: begin
        pos_sum = 34'(accx_q) + delta;
        accx_d = sat32(pos_sum);
        mul_a = MUL_A_W'($signed(fwd_q[47:16]));
        mul_b = s_q;
        state_d = S_M2_4;
      end
      S_M2_4: begin
        acc_d = (MUL_P_W + 1)'(mul_p);
        mul_a = MUL_A_W'($signed(lat_q[47:16]));
        mul_b = c_q;
        state_d = S_M2_5;
      end
      S_M2_5: begin
        mix = acc_q + (MUL_P_W + 1)'(mul_p) + ROUND_46;
        delta = 34'(mix >>> 46);
        pos_sum = 34'(accy_q) + delta;
        accy_d = sat32(pos_sum);
        fwd_d = '0;
        lat_d = '0;
        cd_req = '{start: 1'b1, vectoring: 1'b0};
        {neg_d, cd_z0} = fold_angle(half32);
        cd_x0 = CW'(GAIN_Q30);
        state_d = S_M2_W2;
      end
      S_M2_W2: begin
        if (cd_done) begin
          c_d = neg_q ? -cd_x[31:0] : cd_x[31:0];
          s_d = neg_q ? -cd_y[31:0] : cd_y[31:0];
          state_d = S_M2_O;
        end
      end
      // hand the pose to the output register
      S_M2_O: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          px_d = accx_q;
          py_d = accy_q;
          ow_d = q30_to_q15(c_q);
          oz_d = q30_to_q15(s_q);
          yaw_d = h32[ZW-1 -: 16];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scale_q <= 16'd7369;
      inv_q <= 4'd6;
      fwd_q <= '0;
      lat_q <= '0;
      head_q <= '0;
      ref_q <= '0;
      captured_q <= 1'b0;
      accx_q <= '0;
      accy_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scale_q <= scale_d;
      inv_q <= inv_d;
      fwd_q <= fwd_d;
      lat_q <= lat_d;
      head_q <= head_d;
      ref_q <= ref_d;
      captured_q <= captured_d;
      accx_q <= accx_d;
      accy_q <= accy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    dif_q <= dif_d;
    el_q <= el_d;
    qw_q <= qw_d;
    qx_q <= qx_d;
    qy_q <= qy_d;
    qz_q <= qz_d;
    acc_q <= acc_d;
    num_q <= num_d;
    den_q <= den_d;
    raw32_q <= raw32_d;
    neg_q <= neg_d;
    c_q <= c_d;
    s_q <= s_d;
    px_q <= px_d;
    py_q <= py_d;
    ow_q <= ow_d;
    oz_q <= oz_d;
    yaw_q <= yaw_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign orient_w_o = ow_q;
  assign orient_z_o = oz_q;
  assign yaw_out_o = yaw_q;

endmodule

@@ src/mdr_mul.sv @@
// shared signed multiplier with a registered product
module mdr_mul
  import mdr_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ src/mdr_cordic.sv @@
// iterative cordic unit, one micro-rotation per cycle, vectoring or rotation
module mdr_cordic
  import mdr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_req_t          req_i,
  input  logic signed [CW-1:0] x0_i,
  input  logic signed [CW-1:0] y0_i,
  input  logic [ZW-1:0]        z0_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic [ZW-1:0]        z_o
);

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic [ZW-1:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d, vec_q, vec_d;
  logic signed [CW-1:0] xs, ys;
  logic [ZW-1:0] ang;
  logic pos_dir;

  // one micro-rotation on the current vector
  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    ang = atan_entry(i_q);
    pos_dir = vec_q ? y_q[CW-1] : !z_q[ZW-1];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    busy_d = busy_q;
    vec_d = vec_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d = x0_i;
      y_d = y0_i;
      z_d = z0_i;
      i_d = '0;
      busy_d = 1'b1;
      vec_d = req_i.vectoring;
    end else if (busy_q) begin
      if (pos_dir) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - ang;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + ang;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
      vec_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q <= i_d;
      vec_q <= vec_d;
    end
  end

  // vector and angle registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule
